### rtl/sha1md_pkg.sv
// Shared types and constants for the SHA-1 message digest core.
package sha1md_pkg;

  localparam int NUM_WORDS   = 5;
  localparam int ROUND_W     = 7;
  localparam int FILL_W      = 6;
  localparam int BLK_CNT_W   = 55;
  localparam int WORD_NUM_W  = 3;

  typedef logic [31:0]                word_t;
  typedef logic [NUM_WORDS-1:0][31:0] chain_t;
  typedef logic [7:0]                 byte_t;

  // Index 0 is H0.
  localparam chain_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                               32'hEFCDAB89, 32'h67452301};

  localparam logic [ROUND_W-1:0]    LAST_ROUND = ROUND_W'(79);
  localparam logic [FILL_W-1:0]     LAST_FILL  = FILL_W'(63);
  localparam logic [FILL_W-1:0]     LEN_POS    = FILL_W'(56);
  localparam logic [WORD_NUM_W-1:0] LAST_WORD  = WORD_NUM_W'(NUM_WORDS - 1);
  localparam byte_t                 PAD_BYTE   = 8'h80;

  typedef struct packed {
    logic load;
    logic step;
    logic [ROUND_W-1:0] round;
  } round_ctrl_t;

  typedef struct packed {
    logic shift_byte;
    logic step;
  } sched_ctrl_t;

endpackage

### rtl/sha1_message_digest_core.sv
// SHA-1 message digest core: byte intake, padding sequencer and digest output.
//
// Message bytes enter one per item while the core is idle.
// The 64th byte of a block starts a compression: 80 rounds through the
// single shared round unit, one a cycle, then the chaining-value add.
// The end-of-message item starts padding, which shifts one pad or length
// byte a cycle into the block buffer: 64 - fill bytes when the tail holds
// fewer than 56 bytes, else 128 - fill across two blocks (72 at most), each
// block followed by a compression. The five digest words H0..H4 then come
// out one per accepted result item, and the core returns to the initial
// chaining values. in_stall is high whenever the core is not idle.
module sha1_message_digest_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_number,
  output logic        out_last_word
);
  import sha1md_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_ADD   = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  chain_t                  h_r, h_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic [BLK_CNT_W-1:0]    blk_cnt_r, blk_cnt_nxt;
  logic [63:0]             len_r, len_nxt;
  logic [ROUND_W-1:0]      round_r, round_nxt;
  logic [WORD_NUM_W-1:0]   word_r, word_nxt;
  logic                    pad_mode_r, pad_mode_nxt;
  logic                    first_r, first_nxt;
  logic                    lenok_r, lenok_nxt;
  logic                    fin_r, fin_nxt;

  logic                    in_acc;
  logic                    len_slot;
  logic [FILL_W-1:0]       fill_inc;
  logic [FILL_W-1:0]       fill_after;
  logic [BLK_CNT_W-1:0]    blk_after;
  byte_t                   pad_byte;
  byte_t                   sched_byte;
  word_t                   w_cur;
  chain_t                  work;
  round_ctrl_t             rctrl;
  sched_ctrl_t             sctrl;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign fill_inc  = fill_r + FILL_W'(1);
  assign len_slot  = lenok_r && (fill_r >= LEN_POS);

  always_comb begin
    if (first_r) begin
      pad_byte = PAD_BYTE;
    end else if (len_slot) begin
      pad_byte = len_r[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign sched_byte = (state_r == ST_PAD) ? pad_byte : in_data_byte;

  // Bit count of completed blocks always has its low nine bits clear.
  assign fill_after = in_byte_present ? fill_inc : fill_r;
  assign blk_after  = (in_byte_present && fill_r == LAST_FILL) ?
                      blk_cnt_r + BLK_CNT_W'(1) : blk_cnt_r;

  always_comb begin
    state_nxt    = state_r;
    h_nxt        = h_r;
    fill_nxt     = fill_r;
    blk_cnt_nxt  = blk_cnt_r;
    len_nxt      = len_r;
    round_nxt    = round_r;
    word_nxt     = word_r;
    pad_mode_nxt = pad_mode_r;
    first_nxt    = first_r;
    lenok_nxt    = lenok_r;
    fin_nxt      = fin_r;
    rctrl        = '0;
    rctrl.round  = round_r;
    sctrl        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          fin_nxt   = 1'b0;
          first_nxt = 1'b1;
          lenok_nxt = 1'b0;
          if (in_end_of_message) begin
            len_nxt      = {blk_after, fill_after, 3'b000};
            pad_mode_nxt = 1'b1;
            state_nxt    = ST_PAD;
          end
          if (in_byte_present) begin
            sctrl.shift_byte = 1'b1;
            fill_nxt         = fill_inc;
            blk_cnt_nxt      = blk_after;
            if (fill_r == LAST_FILL) begin
              rctrl.load = 1'b1;
              round_nxt  = '0;
              state_nxt  = ST_ROUND;
            end
          end
        end
      end
      ST_PAD: begin
        sctrl.shift_byte = 1'b1;
        fill_nxt         = fill_inc;
        first_nxt        = 1'b0;
        if (first_r) begin
          lenok_nxt = (fill_r < LEN_POS);
        end
        if (!first_r && len_slot) begin
          len_nxt = {len_r[55:0], 8'h00};
        end
        if (fill_r == LAST_FILL) begin
          fin_nxt    = !first_r && lenok_r;
          rctrl.load = 1'b1;
          round_nxt  = '0;
          state_nxt  = ST_ROUND;
        end
      end
      ST_ROUND: begin
        rctrl.step = 1'b1;
        sctrl.step = 1'b1;
        round_nxt  = round_r + ROUND_W'(1);
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          h_nxt[i] = h_r[i] + work[i];
        end
        if (!pad_mode_r) begin
          state_nxt = ST_IDLE;
        end else if (fin_r) begin
          word_nxt  = '0;
          state_nxt = ST_EMIT;
        end else begin
          // padding spills into, or starts in, a fresh block
          lenok_nxt = 1'b1;
          state_nxt = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (!out_stall) begin
          if (word_r == LAST_WORD) begin
            h_nxt        = H_INIT;
            fill_nxt     = '0;
            blk_cnt_nxt  = '0;
            pad_mode_nxt = 1'b0;
            state_nxt    = ST_IDLE;
          end else begin
            word_nxt = word_r + WORD_NUM_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      h_r        <= H_INIT;
      fill_r     <= '0;
      blk_cnt_r  <= '0;
      round_r    <= '0;
      word_r     <= '0;
      pad_mode_r <= 1'b0;
      first_r    <= 1'b0;
      lenok_r    <= 1'b0;
      fin_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      h_r        <= h_nxt;
      fill_r     <= fill_nxt;
      blk_cnt_r  <= blk_cnt_nxt;
      round_r    <= round_nxt;
      word_r     <= word_nxt;
      pad_mode_r <= pad_mode_nxt;
      first_r    <= first_nxt;
      lenok_r    <= lenok_nxt;
      fin_r      <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

  sha1md_sched u_sched (
    .clk     (clk),
    .ctrl    (sctrl),
    .byte_in (sched_byte),
    .w_out   (w_cur)
  );

  sha1md_round u_round (
    .clk      (clk),
    .ctrl     (rctrl),
    .chain_in (h_r),
    .w_in     (w_cur),
    .work_out (work)
  );

  assign out_valid       = (state_r == ST_EMIT);
  assign out_digest_word = h_r[word_r];
  assign out_word_number = word_r;
  assign out_last_word   = (word_r == LAST_WORD);

endmodule

### rtl/sha1md_sched.sv
// Block buffer as a 512-bit shift line that also runs the message schedule.
module sha1md_sched (
  input  logic                      clk,
  input  sha1md_pkg::sched_ctrl_t   ctrl,
  input  sha1md_pkg::byte_t         byte_in,
  output sha1md_pkg::word_t         w_out
);
  import sha1md_pkg::*;

  logic [511:0] blk_r;
  logic [511:0] blk_nxt;
  word_t        mix;
  word_t        w_new;

  // Window holds w[t..t+15], w[t] on top.
  assign mix   = blk_r[95:64] ^ blk_r[255:224] ^ blk_r[447:416] ^ blk_r[511:480];
  assign w_new = {mix[30:0], mix[31]};
  assign w_out = blk_r[511:480];

  always_comb begin
    blk_nxt = blk_r;
    if (ctrl.shift_byte) begin
      blk_nxt = {blk_r[503:0], byte_in};
    end else if (ctrl.step) begin
      blk_nxt = {blk_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

### rtl/sha1md_round.sv
// Shared SHA-1 round unit with the a..e working registers.
module sha1md_round (
  input  logic                      clk,
  input  sha1md_pkg::round_ctrl_t   ctrl,
  input  sha1md_pkg::chain_t        chain_in,
  input  sha1md_pkg::word_t         w_in,
  output sha1md_pkg::chain_t        work_out
);
  import sha1md_pkg::*;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  chain_t work_r;
  chain_t work_nxt;
  word_t  a, b, c, d, e;
  word_t  f, k, tmp;

  assign a = work_r[0];
  assign b = work_r[1];
  assign c = work_r[2];
  assign d = work_r[3];
  assign e = work_r[4];

  always_comb begin
    if (ctrl.round < ROUND_W'(20)) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (ctrl.round < ROUND_W'(40)) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (ctrl.round < ROUND_W'(60)) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign tmp = {a[26:0], a[31:27]} + f + e + k + w_in;

  always_comb begin
    work_nxt = work_r;
    if (ctrl.load) begin
      work_nxt = chain_in;
    end else if (ctrl.step) begin
      work_nxt[0] = tmp;
      work_nxt[1] = a;
      work_nxt[2] = {b[1:0], b[31:2]};
      work_nxt[3] = c;
      work_nxt[4] = d;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  assign work_out = work_r;

endmodule

### rtl/sha1md_chk.sv
// Port-level checker for the SHA-1 message digest core, with its bind.
module sha1md_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_data_byte,
  input logic        in_byte_present,
  input logic        in_end_of_message,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_number,
  input logic        out_last_word
);

  a_last_flag: assert property (@(posedge clk)
    out_valid |-> (out_last_word == (out_word_number == 3'd4)))
    else $error("last_word does not match word 4");

  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=>
      out_valid && (out_word_number == 3'($past(out_word_number) + 3'd1)))
    else $error("digest words out of order");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_digest_word) && $stable(out_word_number))
    else $error("stalled result item changed");

  a_busy_emit: assert property (@(posedge clk)
    out_valid |-> in_stall)
    else $error("input taken while digest is out");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sha1_message_digest_core sha1md_chk u_chk (.*);

### tb/sha1_digest_checker.sv
// Watches both channels of the SHA-1 core, predicts each digest and compares it.
`timescale 1ns / 100ps

module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_number,
  input  logic        out_last_word,
  output int          mismatch_count,
  output int          words_due,
  output int          words_checked
);

  localparam sha1md_pkg::word_t K_CH     = 32'h5A827999;
  localparam sha1md_pkg::word_t K_PARITY = 32'h6ED9EBA1;
  localparam sha1md_pkg::word_t K_MAJ    = 32'h8F1BBCDC;
  localparam sha1md_pkg::word_t K_TAIL   = 32'hCA62C1D6;
  localparam int BLOCK_BYTES = 64;
  localparam int DUE_DEPTH   = 16;

  typedef logic [BLOCK_BYTES-1:0][7:0] block_t;

  typedef struct packed {
    sha1md_pkg::word_t word;
    logic [2:0]        number;
    logic              last;
  } digest_item_t;

  sha1md_pkg::chain_t chain;
  block_t             block_bytes;
  int unsigned        fill;
  logic [63:0]        bit_count;
  digest_item_t       digest_due [DUE_DEPTH];
  int unsigned        due_rd;
  int unsigned        due_wr;

  // One 80-round compression; byte 0 of the block is the most significant of W0.
  function automatic sha1md_pkg::chain_t sha1_compress(input sha1md_pkg::chain_t cv,
                                                        input block_t blk);
    sha1md_pkg::word_t sched [80];
    sha1md_pkg::word_t a, b, c, d, e, f, k, tmp, x;
    int t;
    for (t = 0; t < 16; t++)
      sched[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (t = 16; t < 80; t++) begin
      x = sched[t-3] ^ sched[t-8] ^ sched[t-14] ^ sched[t-16];
      sched[t] = {x[30:0], x[31]};
    end
    a = cv[0];
    b = cv[1];
    c = cv[2];
    d = cv[3];
    e = cv[4];
    for (t = 0; t < 80; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K_PARITY;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = K_TAIL;
      end
      tmp = {a[26:0], a[31:27]} + f + e + k + sched[t];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = tmp;
    end
    cv[0] = cv[0] + a;
    cv[1] = cv[1] + b;
    cv[2] = cv[2] + c;
    cv[3] = cv[3] + d;
    cv[4] = cv[4] + e;
    return cv;
  endfunction

  task automatic restart_hash();
    chain     = sha1md_pkg::H_INIT;
    fill      = 0;
    bit_count = '0;
  endtask

  // Absorb one accepted item; an end mark pads, finishes and queues five words.
  task automatic absorb_item(input logic [7:0] data, input logic present, input logic eom);
    int unsigned pos;
    logic [63:0] total;
    digest_item_t item;
    if (present) begin
      block_bytes[fill] = data;
      fill++;
      if (fill == BLOCK_BYTES) begin
        chain     = sha1_compress(chain, block_bytes);
        bit_count = bit_count + 64'd512;
        fill      = 0;
      end
    end
    if (eom) begin
      pos   = fill;
      total = bit_count + 64'(fill) * 64'd8;
      block_bytes[pos] = sha1md_pkg::PAD_BYTE;
      pos++;
      // tail too long for the length field: spill into an extra block
      if (pos > sha1md_pkg::LEN_POS) begin
        while (pos < BLOCK_BYTES) begin
          block_bytes[pos] = 8'h00;
          pos++;
        end
        chain = sha1_compress(chain, block_bytes);
        pos   = 0;
      end
      while (pos < sha1md_pkg::LEN_POS) begin
        block_bytes[pos] = 8'h00;
        pos++;
      end
      for (int i = 0; i < 8; i++)
        block_bytes[sha1md_pkg::LEN_POS + i] = total[63 - 8*i -: 8];
      chain = sha1_compress(chain, block_bytes);
      for (int i = 0; i < sha1md_pkg::NUM_WORDS; i++) begin
        item.word   = chain[i];
        item.number = 3'(i);
        item.last   = (3'(i) == sha1md_pkg::LAST_WORD);
        digest_due[due_wr % DUE_DEPTH] = item;
        due_wr++;
      end
      restart_hash();
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $realtime, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    digest_item_t want;
    if (!rst_n) begin
      restart_hash();
      block_bytes    = '0;
      due_rd         = 0;
      due_wr         = 0;
      mismatch_count = 0;
      words_checked  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_wr == due_rd) begin
          report_mismatch($sformatf("unexpected digest word %08h number %0d",
                                    out_digest_word, out_word_number));
        end else begin
          want = digest_due[due_rd % DUE_DEPTH];
          due_rd++;
          words_checked++;
          if (out_digest_word !== want.word)
            report_mismatch($sformatf("word %0d: digest_word %08h, expected %08h",
                                      want.number, out_digest_word, want.word));
          if (out_word_number !== want.number)
            report_mismatch($sformatf("word_number %0d, expected %0d",
                                      out_word_number, want.number));
          if (out_last_word !== want.last)
            report_mismatch($sformatf("word %0d: last_word %0b, expected %0b",
                                      want.number, out_last_word, want.last));
        end
      end
      if (in_valid && !in_stall)
        absorb_item(in_data_byte, in_byte_present, in_end_of_message);
    end
    words_due = int'(due_wr - due_rd);
  end

endmodule

### tb/sha1_message_digest_core_test.sv
// Stimulus, reset and verdict for the SHA-1 message digest core.
`timescale 1ns / 100ps

module sha1_message_digest_core_test;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int MSG_ITEMS    = 300;
  localparam int MIN_MESSAGES = 12;
  localparam int DRAIN_CYCLES = 300;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_TWO_OF_THREE,
    STALL_HALF
  } stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_number;
  logic        out_last_word;

  int mismatch_count;
  int words_due;
  int words_checked;

  int          cycle_count = 0;
  int          burst_left = 0;
  int          message_items = 0;
  int          idle_items = 0;
  int          messages_sent = 0;
  int          bytes_sent = 0;
  int          longest_message = 0;
  logic [31:0] stall_tick;
  stall_mode_t stall_mode;

  sha1_message_digest_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digest_word   (out_digest_word),
    .out_word_number   (out_word_number),
    .out_last_word     (out_last_word)
  );

  sha1_digest_checker digest_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digest_word   (out_digest_word),
    .out_word_number   (out_word_number),
    .out_last_word     (out_last_word),
    .mismatch_count    (mismatch_count),
    .words_due         (words_due),
    .words_checked     (words_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digest words still due", cycle_count, words_due);
      $display("sha1_message_digest_core verification failed");
      $finish;
    end
  end

  // Receiver back-pressure: pick a new random pattern whenever the low six bits of stall_tick are zero.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_tick <= '0;
      stall_mode <= STALL_NONE;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_tick[5:0] == 6'd0)
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE:         out_stall <= 1'b0;
        STALL_RANDOM:       out_stall <= ($urandom_range(0, 2) == 0);
        STALL_TWO_OF_THREE: out_stall <= (stall_tick % 3 != 0);
        default:            out_stall <= stall_tick[2];
      endcase
    end
  end

  // Present one item and hold it until accepted; called at a rising edge.
  task automatic send_item(input logic [7:0] data, input logic present, input logic eom);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_data_byte      <= data;
    in_byte_present   <= present;
    in_end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (present || eom)
      message_items++;
    else
      idle_items++;
    if (present)
      bytes_sent++;
  endtask

  // Random-content message; the end mark rides on the last byte or stands alone.
  task automatic send_message(input int len);
    logic eom_on_byte;
    eom_on_byte = (len > 0) && $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, eom_on_byte && (i == len - 1));
    end
    if (!eom_on_byte)
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    messages_sent++;
    if (len > longest_message)
      longest_message = len;
  endtask

  initial begin
    int len;
    int pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle item, empty message, "abc", extreme bytes, one-byte message, empty message
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1);
    messages_sent += 5;

    // tail that just fits, and tails that need the extra padding block
    send_message(55);
    send_message(56);
    send_message(63);

    while (message_items < MSG_ITEMS || messages_sent < MIN_MESSAGES) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)
        len = $urandom_range(0, 20);
      else if (pick < 9)
        len = $urandom_range(52, 68);
      else
        len = $urandom_range(116, 132);
      send_message(len);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d messages, %0d bytes, %0d idle items; longest random message %0d bytes",
             messages_sent, bytes_sent, idle_items, longest_message);
    $display("Checked %0d digest words, %0d mismatches", words_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("sha1_message_digest_core verification clean");
    end else begin
      $display("sha1_message_digest_core verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/sha1md_pkg.sv
rtl/sha1md_sched.sv
rtl/sha1md_round.sv
rtl/sha1_message_digest_core.sv
rtl/sha1md_chk.sv
tb/sha1_digest_checker.sv
tb/sha1_message_digest_core_test.sv
